// ===== src/line_segment_rect_clipper_top_macros.svh =====
// Assertion helpers shared by the clipper modules.
`ifndef LINE_SEGMENT_RECT_CLIPPER_TOP_MACROS_SVH
`define LINE_SEGMENT_RECT_CLIPPER_TOP_MACROS_SVH

// Checks a property on every rising clock edge, skipped while reset is active.
`define LSRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define LSRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lsrc_pkg.sv =====
package lsrc_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH  = 2;

    localparam int WIN_LEFT_RESET   = 0;
    localparam int WIN_TOP_RESET    = 0;
    localparam int WIN_RIGHT_RESET  = 639;
    localparam int WIN_BOTTOM_RESET = 479;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_WIN_LEFT   = 2'd0,
        REG_WIN_TOP    = 2'd1,
        REG_WIN_RIGHT  = 2'd2,
        REG_WIN_BOTTOM = 2'd3
    } cfg_reg_t;

    // Region code bits of one endpoint.
    localparam logic [3:0] RC_LEFT   = 4'b0001;
    localparam logic [3:0] RC_RIGHT  = 4'b0010;
    localparam logic [3:0] RC_TOP    = 4'b0100;
    localparam logic [3:0] RC_BOTTOM = 4'b1000;

    localparam int MAX_ROUNDS  = 8;
    localparam int ROUND_WIDTH = 4;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_start;
        logic update;
        logic out_load;
        logic visible;
    } cmd_t;

    typedef struct packed {
        logic [3:0] code0;
        logic [3:0] code1;
        logic       div_done;
    } status_t;

endpackage

// ===== src/lsrc_regs.sv =====
module lsrc_regs #(
    parameter int COORD_WIDTH = lsrc_pkg::COORD_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [lsrc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic signed [COORD_WIDTH-1:0]         cfg_wr_data,
    output logic signed [COORD_WIDTH-1:0]         win_left,
    output logic signed [COORD_WIDTH-1:0]         win_top,
    output logic signed [COORD_WIDTH-1:0]         win_right,
    output logic signed [COORD_WIDTH-1:0]         win_bottom
);

    logic signed [COORD_WIDTH-1:0] win_left_reg;
    logic signed [COORD_WIDTH-1:0] win_top_reg;
    logic signed [COORD_WIDTH-1:0] win_right_reg;
    logic signed [COORD_WIDTH-1:0] win_bottom_reg;

    // Reset values wrap to the coordinate width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg   <= COORD_WIDTH'(lsrc_pkg::WIN_LEFT_RESET);
            win_top_reg    <= COORD_WIDTH'(lsrc_pkg::WIN_TOP_RESET);
            win_right_reg  <= COORD_WIDTH'(lsrc_pkg::WIN_RIGHT_RESET);
            win_bottom_reg <= COORD_WIDTH'(lsrc_pkg::WIN_BOTTOM_RESET);
        end else if (cfg_wr_en) begin
            case (lsrc_pkg::cfg_reg_t'(cfg_index))
                lsrc_pkg::REG_WIN_LEFT: begin
                    win_left_reg <= cfg_wr_data;
                end
                lsrc_pkg::REG_WIN_TOP: begin
                    win_top_reg <= cfg_wr_data;
                end
                lsrc_pkg::REG_WIN_RIGHT: begin
                    win_right_reg <= cfg_wr_data;
                end
                lsrc_pkg::REG_WIN_BOTTOM: begin
                    win_bottom_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign win_left   = win_left_reg;
    assign win_top    = win_top_reg;
    assign win_right  = win_right_reg;
    assign win_bottom = win_bottom_reg;

endmodule

// ===== src/lsrc_div.sv =====
`include "line_segment_rect_clipper_top_macros.svh"

module lsrc_div #(
    parameter int DW = lsrc_pkg::COORD_WIDTH + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [2*DW-1:0]   dividend,
    input  logic [DW-1:0]     divisor,
    output logic [DW-1:0]     quotient,
    output logic              done
);

    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] qsh_reg;
    logic [DW:0]   trial;

    // Restoring division, one quotient bit per cycle. The quotient is known to
    // fit in DW bits, so the upper half of the dividend starts as remainder.
    assign trial = {rem_reg, qsh_reg[DW-1]} - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[2*DW-1:DW];
            qsh_reg <= dividend[DW-1:0];
        end else if (busy_reg) begin
            if (!trial[DW]) begin
                rem_reg <= trial[DW-1:0];
            end else begin
                rem_reg <= {rem_reg[DW-2:0], qsh_reg[DW-1]};
            end
            qsh_reg <= {qsh_reg[DW-2:0], ~trial[DW]};
        end
    end

    assign quotient = qsh_reg;
    assign done     = done_reg;

    `LSRC_ASSERT(a_div_start_idle, aclk, aresetn, start |-> !busy_reg, "divider restarted while busy")
    `LSRC_ASSERT(a_div_done_after_busy, aclk, aresetn, done_reg |-> $past(busy_reg), "divider done without work")

endmodule

// ===== src/lsrc_dp.sv =====
module lsrc_dp #(
    parameter int COORD_WIDTH = lsrc_pkg::COORD_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lsrc_pkg::cmd_t                cmd,
    output lsrc_pkg::status_t             status,
    input  logic signed [COORD_WIDTH-1:0] win_left,
    input  logic signed [COORD_WIDTH-1:0] win_top,
    input  logic signed [COORD_WIDTH-1:0] win_right,
    input  logic signed [COORD_WIDTH-1:0] win_bottom,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic                          visible,
    output logic signed [COORD_WIDTH-1:0] clip_start_x,
    output logic signed [COORD_WIDTH-1:0] clip_start_y,
    output logic signed [COORD_WIDTH-1:0] clip_end_x,
    output logic signed [COORD_WIDTH-1:0] clip_end_y
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_WIDTH-1:0] px0_reg, py0_reg, px1_reg, py1_reg;
    logic signed [COORD_WIDTH-1:0] bound_reg, base_reg;
    logic                          sel_reg, tb_reg, neg_reg;
    logic [DW-1:0]                 tmag_reg, nmag_reg, dmag_reg;
    logic [PW-1:0]                 prod_reg;

    logic                          vis_reg;
    logic signed [COORD_WIDTH-1:0] out_sx_reg, out_sy_reg, out_ex_reg, out_ey_reg;

    logic [3:0]                    code0, code1, csel;
    logic                          sel_next, tb_next, neg_next;
    logic signed [COORD_WIDTH-1:0] p_x, p_y, q_x, q_y;
    logic signed [COORD_WIDTH-1:0] bound_next, base_next, qa, pa, pb;
    logic signed [DW-1:0]          t, num, den;
    logic [DW-1:0]                 tmag_next, nmag_next, dmag_next;
    logic [DW-1:0]                 quot;
    logic                          div_done;
    logic signed [DW:0]            sum;
    logic signed [COORD_WIDTH-1:0] newc, new_x, new_y;

    // Region codes of both current endpoints.
    always_comb begin
        code0 = '0;
        code1 = '0;
        if (px0_reg < win_left)   code0 = code0 | lsrc_pkg::RC_LEFT;
        if (px0_reg > win_right)  code0 = code0 | lsrc_pkg::RC_RIGHT;
        if (py0_reg < win_top)    code0 = code0 | lsrc_pkg::RC_TOP;
        if (py0_reg > win_bottom) code0 = code0 | lsrc_pkg::RC_BOTTOM;
        if (px1_reg < win_left)   code1 = code1 | lsrc_pkg::RC_LEFT;
        if (px1_reg > win_right)  code1 = code1 | lsrc_pkg::RC_RIGHT;
        if (py1_reg < win_top)    code1 = code1 | lsrc_pkg::RC_TOP;
        if (py1_reg > win_bottom) code1 = code1 | lsrc_pkg::RC_BOTTOM;
    end

    // Pick the endpoint to move and the edge, and form the ratio operands.
    always_comb begin
        sel_next = (code0 == 4'b0000);
        csel     = sel_next ? code1 : code0;
        p_x      = sel_next ? px1_reg : px0_reg;
        p_y      = sel_next ? py1_reg : py0_reg;
        q_x      = sel_next ? px0_reg : px1_reg;
        q_y      = sel_next ? py0_reg : py1_reg;
        tb_next  = |(csel & (lsrc_pkg::RC_TOP | lsrc_pkg::RC_BOTTOM));
        if (tb_next) begin
            bound_next = (|(csel & lsrc_pkg::RC_TOP)) ? win_top : win_bottom;
            qa         = q_y;
            base_next  = q_x;
            pa         = p_y;
            pb         = p_x;
        end else begin
            bound_next = (|(csel & lsrc_pkg::RC_LEFT)) ? win_left : win_right;
            qa         = q_x;
            base_next  = q_y;
            pa         = p_x;
            pb         = p_y;
        end
        t         = DW'(bound_next) - DW'(qa);
        num       = DW'(pb) - DW'(base_next);
        den       = DW'(pa) - DW'(qa);
        neg_next  = t[DW-1] ^ num[DW-1] ^ den[DW-1];
        tmag_next = t[DW-1]   ? $unsigned(-t)   : $unsigned(t);
        nmag_next = num[DW-1] ? $unsigned(-num) : $unsigned(num);
        dmag_next = den[DW-1] ? $unsigned(-den) : $unsigned(den);
    end

    // New position of the moved endpoint; the result lies between the
    // endpoints, so the low bits carry the whole value.
    always_comb begin
        if (neg_reg) begin
            sum = (DW + 1)'(base_reg) - $signed({1'b0, quot});
        end else begin
            sum = (DW + 1)'(base_reg) + $signed({1'b0, quot});
        end
        newc  = sum[COORD_WIDTH-1:0];
        new_x = tb_reg ? newc : bound_reg;
        new_y = tb_reg ? bound_reg : newc;
    end

    lsrc_div #(
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (dmag_reg),
        .quotient (quot),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px0_reg <= start_x;
            py0_reg <= start_y;
            px1_reg <= end_x;
            py1_reg <= end_y;
        end else if (cmd.update) begin
            if (sel_reg) begin
                px1_reg <= new_x;
                py1_reg <= new_y;
            end else begin
                px0_reg <= new_x;
                py0_reg <= new_y;
            end
        end
        if (cmd.setup) begin
            sel_reg   <= sel_next;
            tb_reg    <= tb_next;
            neg_reg   <= neg_next;
            bound_reg <= bound_next;
            base_reg  <= base_next;
            tmag_reg  <= tmag_next;
            nmag_reg  <= nmag_next;
            dmag_reg  <= dmag_next;
        end
        if (cmd.mul) begin
            prod_reg <= PW'(tmag_reg) * PW'(nmag_reg);
        end
        if (cmd.out_load) begin
            vis_reg    <= cmd.visible;
            out_sx_reg <= cmd.visible ? px0_reg : '0;
            out_sy_reg <= cmd.visible ? py0_reg : '0;
            out_ex_reg <= cmd.visible ? px1_reg : '0;
            out_ey_reg <= cmd.visible ? py1_reg : '0;
        end
    end

    assign status = '{code0: code0, code1: code1, div_done: div_done};

    assign visible      = vis_reg;
    assign clip_start_x = out_sx_reg;
    assign clip_start_y = out_sy_reg;
    assign clip_end_x   = out_ex_reg;
    assign clip_end_y   = out_ey_reg;

endmodule

// ===== src/lsrc_ctrl.sv =====
`include "line_segment_rect_clipper_top_macros.svh"

module lsrc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  lsrc_pkg::status_t status,
    output lsrc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t                             state_reg, state_next;
    logic [lsrc_pkg::ROUND_WIDTH-1:0]   round_reg, round_next;
    logic                               vis_reg, vis_next;
    logic                               m_valid_reg, m_valid_next;
    logic                               out_free;

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        vis_next   = vis_reg;
        cmd        = '0;
        cmd.visible = vis_reg;
        out_free   = !m_valid_reg || m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    round_next = '0;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((status.code0 | status.code1) == 4'b0000) begin
                    vis_next   = 1'b1;
                    state_next = ST_FINISH;
                end else if ((|(status.code0 & status.code1)) ||
                             (round_reg == lsrc_pkg::ROUND_WIDTH'(lsrc_pkg::MAX_ROUNDS))) begin
                    vis_next   = 1'b0;
                    state_next = ST_FINISH;
                end else begin
                    cmd.setup  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                round_next = round_reg + 1'b1;
                state_next = ST_DECIDE;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            round_reg   <= '0;
            vis_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            vis_reg     <= vis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `LSRC_ASSERT(a_no_overwrite, aclk, aresetn, cmd.out_load |-> (!m_valid_reg || m_ready), "result overwritten before transfer")
    `LSRC_ASSERT_NEXT(a_result_shown, aclk, aresetn, cmd.out_load, m_valid_reg, "loaded result not presented")
    `LSRC_ASSERT(a_round_bound, aclk, aresetn, round_reg <= lsrc_pkg::ROUND_WIDTH'(lsrc_pkg::MAX_ROUNDS), "too many clipping rounds")

endmodule

// ===== src/line_segment_rect_clipper_top.sv =====
// Between input transfer and m_valid a segment runs through R clipping rounds, R = 0..8.
// Each round moves one endpoint: setup, a multiply and a restoring divider
// that yields one quotient bit per cycle make up the round.
// Only one segment is in flight; a new one is accepted once the previous result is loaded.
// Reset: aresetn is synchronous, active low; it loads the window registers with
// 0, 0, 639, 479 (wrapped to COORD_WIDTH) and clears m_valid; the result register has no reset.
module line_segment_rect_clipper_top #(
    parameter int COORD_WIDTH = lsrc_pkg::COORD_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // Configuration write port for the window registers.
    input  logic                                 cfg_wr_en,
    input  logic [lsrc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic signed [COORD_WIDTH-1:0]        cfg_wr_data,

    // Segment input channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_start_x,
    input  logic signed [COORD_WIDTH-1:0]        s_start_y,
    input  logic signed [COORD_WIDTH-1:0]        s_end_x,
    input  logic signed [COORD_WIDTH-1:0]        s_end_y,

    // Clipped segment result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_visible,
    output logic signed [COORD_WIDTH-1:0]        m_clip_start_x,
    output logic signed [COORD_WIDTH-1:0]        m_clip_start_y,
    output logic signed [COORD_WIDTH-1:0]        m_clip_end_x,
    output logic signed [COORD_WIDTH-1:0]        m_clip_end_y
);

    // The block is a classic region-code line clipper. The controller walks
    // each segment through clipping rounds; the datapath holds the endpoints,
    // derives their region codes every cycle and computes the new endpoint
    // position as an exact integer ratio truncated toward zero.

    logic signed [COORD_WIDTH-1:0] win_left;
    logic signed [COORD_WIDTH-1:0] win_top;
    logic signed [COORD_WIDTH-1:0] win_right;
    logic signed [COORD_WIDTH-1:0] win_bottom;

    lsrc_pkg::cmd_t    cmd;
    lsrc_pkg::status_t status;

    // Window registers. Writes are expected only while no segment is in work,
    // so the datapath reads them directly without any shadow copy.
    lsrc_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .win_left    (win_left),
        .win_top     (win_top),
        .win_right   (win_right),
        .win_bottom  (win_bottom)
    );

    // Datapath: endpoint registers, region codes, ratio operands, multiplier,
    // shared divider and the result register that drives the m_ payload.
    lsrc_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .win_left     (win_left),
        .win_top      (win_top),
        .win_right    (win_right),
        .win_bottom   (win_bottom),
        .start_x      (s_start_x),
        .start_y      (s_start_y),
        .end_x        (s_end_x),
        .end_y        (s_end_y),
        .visible      (m_visible),
        .clip_start_x (m_clip_start_x),
        .clip_start_y (m_clip_start_y),
        .clip_end_x   (m_clip_end_x),
        .clip_end_y   (m_clip_end_y)
    );

    // Controller: accepts a segment when idle, decides accept or reject from
    // the region codes, sequences the clipping rounds (at most eight) and
    // loads the result register once the previous result has been taken.
    // A new segment transfer may happen while the last result still waits.
    lsrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

endmodule
